// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbbc: property violated");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lbbc: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: sv/lbbc_pkg.sv
`default_nettype none

package lbbc_pkg;

  localparam int unsigned BLOCK_W    = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SLOT_IDX_W = 4;

  // enables of one memory port pair
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

endpackage

`default_nettype wire

// File: sv/lbbc_if.sv
`default_nettype none

// lookup request channel
interface lbbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbbc_pkg::BLOCK_W-1:0] block_number;

  modport source (output valid, output block_number, input ready);
  modport sink   (input valid, input block_number, output ready);
endinterface

// lookup result channel
interface lbbc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lbbc_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [lbbc_pkg::CNT_W-1:0]      disk_reads;
  logic [lbbc_pkg::CNT_W-1:0]      cache_hits;

  modport source (output valid, output hit, output slot_index, output disk_reads,
                  output cache_hits, input ready);
  modport sink   (input valid, input hit, input slot_index, input disk_reads,
                  input cache_hits, output ready);
endinterface

`default_nettype wire

// File: sv/lbbc_rec_mem.sv
`default_nettype none

// recency order memory: position -> slot, position 0 most recent
module lbbc_rec_mem #(
  parameter  int unsigned NUM_SLOTS = 16,
  localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lbbc_pkg::mem_ctl_t ctl_i,
  input  wire logic [SLOT_W-1:0]  raddr_i,
  input  wire logic [SLOT_W-1:0]  waddr_i,
  input  wire logic [SLOT_W-1:0]  wdata_i,
  output logic [SLOT_W-1:0]       slot_o
);

  logic [SLOT_W-1:0]    mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written_q;
  logic [SLOT_W-1:0]    rd_data_q;
  logic [SLOT_W-1:0]    rd_addr_q;
  logic                 rd_written_q;

  // storage with registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q    <= mem_q[raddr_i];
      rd_addr_q    <= raddr_i;
      rd_written_q <= written_q[raddr_i];
    end
  end

  // per position written flags, unwritten positions hold the identity order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (ctl_i.wr_en) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  assign slot_o = rd_written_q ? rd_data_q : rd_addr_q;

endmodule

`default_nettype wire

// File: sv/lbbc_tag_store.sv
`default_nettype none

// slot tags in memory, valid bits in flops, tag compare on read data
module lbbc_tag_store #(
  parameter  int unsigned NUM_SLOTS = 16,
  localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lbbc_pkg::mem_ctl_t           ctl_i,
  input  wire logic [SLOT_W-1:0]            rd_slot_i,
  input  wire logic [SLOT_W-1:0]            wr_slot_i,
  input  wire logic [lbbc_pkg::BLOCK_W-1:0] wr_tag_i,
  input  wire logic [lbbc_pkg::BLOCK_W-1:0] blk_i,
  output logic                              hit_o
);

  logic [lbbc_pkg::BLOCK_W-1:0] tag_mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]         valid_q;
  logic [lbbc_pkg::BLOCK_W-1:0] tag_rd_q;
  logic [SLOT_W-1:0]            rd_slot_q;

  // tag storage with registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      tag_mem_q[wr_slot_i] <= wr_tag_i;
    end
    if (ctl_i.rd_en) begin
      tag_rd_q  <= tag_mem_q[rd_slot_i];
      rd_slot_q <= rd_slot_i;
    end
  end

  // valid bits, set when a slot takes a tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en) begin
      valid_q[wr_slot_i] <= 1'b1;
    end
  end

  // valid bits do not change while a walk is reading
  assign hit_o = valid_q[rd_slot_q] && (tag_rd_q == blk_i);

endmodule

`default_nettype wire

// File: sv/lbbc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

// lookup sequencer: walks the recency order, shifts it, commits the update
module lbbc_ctrl #(
  parameter  int unsigned NUM_SLOTS = 16,
  localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lbbc_in_if.sink                            in_i,
  lbbc_out_if.source                         out_o,
  output lbbc_pkg::mem_ctl_t                 rec_ctl_o,
  output logic [SLOT_W-1:0]                  rec_raddr_o,
  output logic [SLOT_W-1:0]                  rec_waddr_o,
  output logic [SLOT_W-1:0]                  rec_wdata_o,
  input  wire logic [SLOT_W-1:0]             rec_slot_i,
  output lbbc_pkg::mem_ctl_t                 tag_ctl_o,
  output logic [SLOT_W-1:0]                  tag_rd_slot_o,
  output logic [SLOT_W-1:0]                  tag_wr_slot_o,
  output logic [lbbc_pkg::BLOCK_W-1:0]       blk_o,
  input  wire logic                          tag_hit_i
);

  localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(NUM_SLOTS - 1);

  lbbc_pkg::state_e state_q, state_d;

  logic [lbbc_pkg::BLOCK_W-1:0] blk_q;
  logic [SLOT_W-1:0]            rd_pos_q;
  logic                         issue_q;
  logic                         v1_q;
  logic [SLOT_W-1:0]            pos1_q;
  logic                         v2_q;
  logic [SLOT_W-1:0]            pos2_q;
  logic [SLOT_W-1:0]            slot2_q;
  logic                         found_q;
  logic [SLOT_W-1:0]            res_slot_q;
  logic [lbbc_pkg::CNT_W-1:0]   hit_cnt_q;
  logic [lbbc_pkg::CNT_W-1:0]   miss_cnt_q;
  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [lbbc_pkg::SLOT_IDX_W-1:0] out_slot_q;
  logic [lbbc_pkg::CNT_W-1:0]   out_reads_q;
  logic [lbbc_pkg::CNT_W-1:0]   out_hits_q;

  logic                         in_req;
  logic                         walking;
  logic                         stop;
  logic                         rec_re;
  logic                         tag_re;
  logic                         shift_we;
  logic                         commit;
  logic [SLOT_W+3:0]            slot_ext;

  // walk control
  assign in_req   = in_i.valid && in_i.ready;
  assign walking  = (state_q == lbbc_pkg::ST_WALK);
  assign stop     = walking && v2_q && (tag_hit_i || (pos2_q == LAST_POS));
  assign rec_re   = walking && issue_q && !stop;
  assign tag_re   = walking && v1_q && !stop;
  assign shift_we = walking && v2_q && !tag_hit_i && (pos2_q != LAST_POS);
  assign commit   = (state_q == lbbc_pkg::ST_UPDATE) && (!out_valid_q || out_o.ready);
  assign slot_ext = {4'b0000, res_slot_q};

  // recency port: shift entries down during the walk, new head on commit
  assign rec_ctl_o.rd_en = rec_re;
  assign rec_ctl_o.wr_en = shift_we || commit;
  assign rec_raddr_o     = rd_pos_q;
  assign rec_waddr_o     = commit ? '0 : SLOT_W'(pos2_q + SLOT_W'(1));
  assign rec_wdata_o     = commit ? res_slot_q : slot2_q;

  // tag port: read the slot at each position, write the victim on a miss
  assign tag_ctl_o.rd_en = tag_re;
  assign tag_ctl_o.wr_en = commit && !found_q;
  assign tag_rd_slot_o   = rec_slot_i;
  assign tag_wr_slot_o   = res_slot_q;
  assign blk_o           = blk_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbbc_pkg::ST_IDLE: begin
        if (in_req) state_d = lbbc_pkg::ST_WALK;
      end
      lbbc_pkg::ST_WALK: begin
        if (stop) state_d = lbbc_pkg::ST_UPDATE;
      end
      lbbc_pkg::ST_UPDATE: begin
        if (commit) state_d = lbbc_pkg::ST_IDLE;
      end
      default: state_d = lbbc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbbc_pkg::ST_IDLE;
      issue_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= rec_re;
      v2_q    <= tag_re;
      if (in_req) begin
        issue_q <= 1'b1;
      end else if (rec_re && (rd_pos_q == LAST_POS)) begin
        issue_q <= 1'b0;
      end else if (stop) begin
        issue_q <= 1'b0;
      end
      if (commit) begin
        if (found_q) hit_cnt_q <= hit_cnt_q + 32'd1;
        else         miss_cnt_q <= miss_cnt_q + 32'd1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk payload and result register
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      blk_q    <= in_i.block_number;
      rd_pos_q <= '0;
    end else if (rec_re) begin
      rd_pos_q <= SLOT_W'(rd_pos_q + SLOT_W'(1));
    end
    pos1_q  <= rd_pos_q;
    pos2_q  <= pos1_q;
    slot2_q <= rec_slot_i;
    if (stop) begin
      found_q    <= tag_hit_i;
      res_slot_q <= slot2_q;
    end
    if (commit) begin
      out_hit_q   <= found_q;
      out_slot_q  <= slot_ext[3:0];
      out_reads_q <= found_q ? miss_cnt_q : miss_cnt_q + 32'd1;
      out_hits_q  <= found_q ? hit_cnt_q + 32'd1 : hit_cnt_q;
    end
  end

  assign in_i.ready       = (state_q == lbbc_pkg::ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_hit_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.disk_reads = out_reads_q;
  assign out_o.cache_hits = out_hits_q;

  // checks
  `ASSERT_NEVER(a_rec_same_addr, clk_i, rst_ni, rec_ctl_o.rd_en && rec_ctl_o.wr_en && (rec_raddr_o == rec_waddr_o))
  `ASSERT_NEVER(a_pipe_outside_walk, clk_i, rst_ni, (v1_q || v2_q) && (state_q != lbbc_pkg::ST_WALK))
  `ASSERT_PROP(a_one_count_per_req, clk_i, rst_ni, commit |=> ((hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q) + $past(miss_cnt_q) + 32'd1)))
  `ASSERT_PROP(a_hold_update, clk_i, rst_ni, (state_q == lbbc_pkg::ST_UPDATE) && out_valid_q && !out_o.ready |=> (state_q == lbbc_pkg::ST_UPDATE))

endmodule

`default_nettype wire

// File: sv/lru_block_buffer_cache.sv
// Tag and LRU replacement store of a block buffer cache with NUM_SLOTS slots.
// in_i carries one lookup request, a physical block number; out_o returns one
// result per request: hit flag, slot now holding the block, and the running
// disk-read (miss) and hit counts after the request, both wrapping at 32 bits.
// Both channels use valid/ready, a request moves when both are high.
// The walk reads one recency position per cycle from the order memory and then
// that slot's tag; a hit stops the walk at its position, a miss walks on to the
// last position, and one request is in work at a time.
// A finished result sits in the output register; the block takes the next
// request while it waits. If the receiver stalls, the following lookup
// completes its walk and holds before updating until the register frees.
// Reset clears all valid bits and both counters and restores the recency
// order to slot 0 most recent through slot NUM_SLOTS-1 least recent; no
// clearing pass is needed, requests are taken right after reset.
`default_nettype none

module lru_block_buffer_cache #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lbbc_in_if.sink    in_i,
  lbbc_out_if.source out_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  lbbc_pkg::mem_ctl_t           rec_ctl;
  lbbc_pkg::mem_ctl_t           tag_ctl;
  logic [SLOT_W-1:0]            rec_raddr;
  logic [SLOT_W-1:0]            rec_waddr;
  logic [SLOT_W-1:0]            rec_wdata;
  logic [SLOT_W-1:0]            rec_slot;
  logic [SLOT_W-1:0]            tag_rd_slot;
  logic [SLOT_W-1:0]            tag_wr_slot;
  logic [lbbc_pkg::BLOCK_W-1:0] blk;
  logic                         tag_hit;

  // sequencer
  lbbc_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .rec_ctl_o     (rec_ctl),
    .rec_raddr_o   (rec_raddr),
    .rec_waddr_o   (rec_waddr),
    .rec_wdata_o   (rec_wdata),
    .rec_slot_i    (rec_slot),
    .tag_ctl_o     (tag_ctl),
    .tag_rd_slot_o (tag_rd_slot),
    .tag_wr_slot_o (tag_wr_slot),
    .blk_o         (blk),
    .tag_hit_i     (tag_hit)
  );

  // recency order
  lbbc_rec_mem #(.NUM_SLOTS(NUM_SLOTS)) u_rec_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rec_ctl),
    .raddr_i (rec_raddr),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .slot_o  (rec_slot)
  );

  // tags and valid bits
  lbbc_tag_store #(.NUM_SLOTS(NUM_SLOTS)) u_tag_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tag_ctl),
    .rd_slot_i (tag_rd_slot),
    .wr_slot_i (tag_wr_slot),
    .wr_tag_i  (blk),
    .blk_i     (blk),
    .hit_o     (tag_hit)
  );

endmodule

`default_nettype wire

// File: tb/tb_lru_block_buffer_cache.sv
`timescale 1ns / 1ps

module tb_lru_block_buffer_cache;

  localparam int unsigned NUM_SLOTS   = 16;
  localparam int unsigned WS_SIZE     = 24;
  localparam int unsigned HOT_SIZE    = 6;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = NUM_SLOTS + 8;
  localparam int unsigned DIR_ROWS    = 23;

  typedef struct packed {
    logic                            hit;
    logic [lbbc_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [lbbc_pkg::CNT_W-1:0]      disk_reads;
    logic [lbbc_pkg::CNT_W-1:0]      cache_hits;
  } lookup_res_t;

  // one stimulus row, with an optional hand-written result
  typedef struct packed {
    logic [lbbc_pkg::BLOCK_W-1:0] blk;
    logic                         typed;
    lookup_res_t                  res;
  } lookup_row_t;

  localparam lookup_res_t NO_RES = '{1'b0, 4'd0, 32'd0, 32'd0};

  // directed lookups: invalid tag match, extremes, deep hits, evictions
  localparam lookup_row_t DIR_TABLE [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 4'd15, 32'd1, 32'd0}},
    '{32'h0000_0000, 1'b1, '{1'b1, 4'd15, 32'd1, 32'd1}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd14, 32'd2, 32'd1}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd14, 32'd2, 32'd2}},
    '{32'h8000_0000, 1'b1, '{1'b0, 4'd13, 32'd3, 32'd2}},
    '{32'h0000_0001, 1'b1, '{1'b0, 4'd12, 32'd4, 32'd2}},
    '{32'h0000_0000, 1'b1, '{1'b1, 4'd15, 32'd4, 32'd3}},
    '{32'h0000_0002, 1'b0, NO_RES},
    '{32'h0000_0004, 1'b0, NO_RES},
    '{32'h0000_0008, 1'b0, NO_RES},
    '{32'h5555_5555, 1'b0, NO_RES},
    '{32'hAAAA_AAAA, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b0, NO_RES},
    '{32'hFFFF_FFFE, 1'b0, NO_RES},
    '{32'h0001_0000, 1'b0, NO_RES},
    '{32'h1357_9BDF, 1'b0, NO_RES},
    '{32'h0F0F_0F0F, 1'b0, NO_RES},
    '{32'hF0F0_F0F0, 1'b0, NO_RES},
    '{32'h00FF_FF00, 1'b0, NO_RES},
    '{32'h1234_5678, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, NO_RES},
    '{32'h0000_0001, 1'b0, NO_RES},
    '{32'h00FF_FF00, 1'b0, NO_RES}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lbbc_in_if  req_if ();
  lbbc_out_if res_if ();

  lru_block_buffer_cache #(
    .NUM_SLOTS(NUM_SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the tag store, recency order and counters
  logic [lbbc_pkg::BLOCK_W-1:0]    tags    [NUM_SLOTS];
  logic                            tag_ok  [NUM_SLOTS];
  logic [lbbc_pkg::SLOT_IDX_W-1:0] lru_list[NUM_SLOTS];
  logic [lbbc_pkg::CNT_W-1:0]      miss_cnt;
  logic [lbbc_pkg::CNT_W-1:0]      hit_cnt;

  lookup_res_t pending_lookups[$];
  lookup_row_t offered_rows[$];
  logic [lbbc_pkg::BLOCK_W-1:0] working_set[WS_SIZE];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned bad_results = 0;
  int unsigned lookups_checked = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;

  initial begin
    req_if.valid        = 1'b0;
    req_if.block_number = '0;
    res_if.ready        = 1'b0;
  end

  // lookup against the shadow store, updating recency and counters
  function automatic lookup_res_t lookup_block(input logic [lbbc_pkg::BLOCK_W-1:0] blk);
    lookup_res_t r;
    int pos;
    int hit_pos = -1;
    logic [lbbc_pkg::SLOT_IDX_W-1:0] s;
    for (pos = 0; pos < NUM_SLOTS; pos++) begin
      if (hit_pos < 0 && tag_ok[lru_list[pos]] && tags[lru_list[pos]] == blk)
        hit_pos = pos;
    end
    if (hit_pos >= 0) begin
      s       = lru_list[hit_pos];
      hit_cnt = hit_cnt + 1'b1;
      r.hit   = 1'b1;
    end else begin
      hit_pos   = NUM_SLOTS - 1;
      s         = lru_list[hit_pos];
      tags[s]   = blk;
      tag_ok[s] = 1'b1;
      miss_cnt  = miss_cnt + 1'b1;
      r.hit     = 1'b0;
    end
    for (pos = hit_pos; pos > 0; pos--) lru_list[pos] = lru_list[pos-1];
    lru_list[0]  = s;
    r.slot_index = s;
    r.disk_reads = miss_cnt;
    r.cache_hits = hit_cnt;
    return r;
  endfunction

  // mostly a working set a bit larger than the store, plus noise and corners
  function automatic logic [lbbc_pkg::BLOCK_W-1:0] pick_block();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(31);
    if (r < 50) return working_set[$urandom_range(WS_SIZE-1)];
    if (r < 75) return working_set[$urandom_range(HOT_SIZE-1)];
    if (r < 90) return $urandom();
    case (k % 4)
      0: return '0;
      1: return '1;
      2: return 32'd1 << k;
      default: return ~(32'd1 << k);
    endcase
  endfunction

  task automatic offer_block(input logic [lbbc_pkg::BLOCK_W-1:0] blk, input logic typed,
                             input lookup_res_t res);
    lookup_row_t row;
    row.blk   = blk;
    row.typed = typed;
    row.res   = res;
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid        <= 1'b0;
      req_if.block_number <= $urandom();
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    offered_rows.push_back(row);
    req_if.valid        <= 1'b1;
    req_if.block_number <= blk;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // requests not yet moved to the pending list still count as outstanding
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (offered_rows.size() != 0 || pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  // result check first, then the newly accepted request
  always @(posedge clk_i) begin
    lookup_res_t want;
    lookup_res_t got;
    lookup_row_t row;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.hit, res_if.slot_index, res_if.disk_reads, res_if.cache_hits};
        if (pending_lookups.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result with no request pending: %p", $time, got);
        end else begin
          want = pending_lookups.pop_front();
          lookups_checked++;
          if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
              got.disk_reads !== want.disk_reads ||
              got.cache_hits !== want.cache_hits) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: mismatch, expected %p, got %p", $time, want, got);
          end
        end
      end
      if (req_if.valid && req_if.ready && offered_rows.size() != 0) begin
        row = offered_rows.pop_front();
        got = lookup_block(req_if.block_number);
        pending_lookups.push_back(row.typed ? row.res : got);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_toggle != hold_seen) begin
        hold_seen    <= hold_toggle;
        hold_left    <= LONG_HOLD;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      tags[i]     = '0;
      tag_ok[i]   = 1'b0;
      lru_list[i] = i[lbbc_pkg::SLOT_IDX_W-1:0];
    end
    miss_cnt = '0;
    hit_cnt  = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < DIR_ROWS; i++)
      offer_block(DIR_TABLE[i].blk, DIR_TABLE[i].typed, DIR_TABLE[i].res);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 71; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 71; end
        default: begin idle_pct = 33; stall_pct <= 33; end
      endcase
      for (i = 0; i < WS_SIZE; i++)
        working_set[i] = (i % 3 == 0) ? i[lbbc_pkg::BLOCK_W-1:0] : $urandom();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long output hold-off while requests keep coming
        if (ph == 0 && i == 40) hold_toggle <= ~hold_toggle;
        offer_block(pick_block(), 1'b0, NO_RES);
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("checked %0d lookups (%0d hits, %0d misses) from a directed table and",
             lookups_checked, hit_cnt, miss_cnt);
    $display("four random phases with input gaps, output stalls and a long hold-off");
    if (bad_results == 0 && pending_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failed checks, %0d results missing", bad_results,
               pending_lookups.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
